FILE: rtl/core/rm_pkg.sv
// ----------------------------------------------------------------------------
// rm_pkg: shared types for the running median block
// Sample type, result widths and the per-chain insert command.
// ----------------------------------------------------------------------------
package rm_pkg;

  localparam int SAMPLE_W = 16;
  localparam int MEDIAN_W = 17;
  localparam int COUNT_W  = 7;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [MEDIAN_W-1:0] median_t;

  // Command broadcast to every cell of one sorted chain.
  typedef struct packed {
    logic    ins;  // insert val at its sorted place
    logic    pop;  // in the same cycle, remove the head
    sample_t val;
  } chain_op_t;

endpackage

FILE: rtl/core/rm_cell.sv
// ----------------------------------------------------------------------------
// rm_cell: one slot of a sorted chain
// Holds one sample and takes its next value from itself, its neighbors or
// the broadcast sample, depending on where the new sample lands.
// ----------------------------------------------------------------------------
module rm_cell import rm_pkg::*; #(
  parameter bit DESC = 1'b0
) (
  input  logic      clk_i,
  input  logic      cell_valid_i,
  input  chain_op_t op_i,
  input  sample_t   prev_val_i,
  input  logic      prev_after_i,
  input  sample_t   next_val_i,
  input  logic      next_after_i,
  output logic      after_o,
  output sample_t   val_o,
  output sample_t   val_d_o
);

  sample_t val_q;
  sample_t val_d;

  // The new sample is placed behind this cell; equal values go behind.
  always_comb begin
    if (DESC) begin
      after_o = cell_valid_i && (op_i.val <= val_q);
    end else begin
      after_o = cell_valid_i && (op_i.val >= val_q);
    end
  end

  always_comb begin
    val_d = val_q;
    if (op_i.ins) begin
      if (!op_i.pop) begin
        if (after_o) begin
          val_d = val_q;
        end else if (prev_after_i) begin
          val_d = op_i.val;
        end else begin
          val_d = prev_val_i;
        end
      end else begin
        // Insert and drop the head: everything ahead of the slot moves up.
        if (next_after_i) begin
          val_d = next_val_i;
        end else if (after_o) begin
          val_d = op_i.val;
        end else begin
          val_d = val_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o   = val_q;
  assign val_d_o = val_d;

endmodule

FILE: rtl/core/rm_chain.sv
// ----------------------------------------------------------------------------
// rm_chain: row of cells kept in sorted order
// The head (cell 0) holds the extreme value: the largest for a descending
// chain, the smallest for an ascending one.
// ----------------------------------------------------------------------------
module rm_chain import rm_pkg::*; #(
  parameter int DEPTH = 32,
  parameter int SZ_W  = 6,
  parameter bit DESC  = 1'b0
) (
  input  logic            clk_i,
  input  logic [SZ_W-1:0] size_i,
  input  chain_op_t       op_i,
  output sample_t         head_o,
  output sample_t         head_d_o
);

  logic    after  [DEPTH];
  sample_t val    [DEPTH];
  sample_t val_d  [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic    prev_after;
    sample_t prev_val;
    logic    next_after;
    sample_t next_val;
    logic    cell_valid;

    assign cell_valid = (SZ_W'(i) < size_i);

    if (i == 0) begin : g_first
      assign prev_after = 1'b1;
      assign prev_val   = val[i];
    end else begin : g_mid
      assign prev_after = after[i-1];
      assign prev_val   = val[i-1];
    end

    if (i == DEPTH-1) begin : g_last
      assign next_after = 1'b0;
      assign next_val   = val[i];
    end else begin : g_inner
      assign next_after = after[i+1];
      assign next_val   = val[i+1];
    end

    rm_cell #(
      .DESC (DESC)
    ) u_cell (
      .clk_i        (clk_i),
      .cell_valid_i (cell_valid),
      .op_i         (op_i),
      .prev_val_i   (prev_val),
      .prev_after_i (prev_after),
      .next_val_i   (next_val),
      .next_after_i (next_after),
      .after_o      (after[i]),
      .val_o        (val[i]),
      .val_d_o      (val_d[i])
    );
  end

  assign head_o   = val[0];
  assign head_d_o = val_d[0];

endmodule

FILE: rtl/core/running_median.sv
// ----------------------------------------------------------------------------
// running_median: streaming median of signed 16-bit samples
// Two sorted chains of cells: a descending lower half and an ascending
// upper half, so the middle values always sit in the two head cells.
// ----------------------------------------------------------------------------
//  channel   direction  signals
//  in        input      in_valid_i, in_stall_o, sample_i, restart_i
//  out       output     out_valid_o, out_stall_i, median_twice_o,
//                       sample_count_o, dropped_o
//
// One transaction per cycle. The result is registered and appears the cycle
// after the input is taken; insertion is a single compare per cell against
// the broadcast sample, and a rebalance moves one head to the other chain.
// Reset clears the fill counts and out_valid_q; cell contents need no clearing.
// The input stalls only while a finished result waits on a stalled output.
// ----------------------------------------------------------------------------
module running_median import rm_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [SAMPLE_W-1:0]  sample_i,
  input  logic                 restart_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [MEDIAN_W-1:0]  median_twice_o,
  output logic [COUNT_W-1:0]   sample_count_o,
  output logic                 dropped_o
);

  localparam int LCAP  = (CAPACITY + 1) / 2;
  localparam int UCAP  = CAPACITY / 2;
  localparam int SZ_W  = $clog2(LCAP + 1);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [SZ_W-1:0] lo_size_q, lo_size_d;
  logic [SZ_W-1:0] up_size_q, up_size_d;
  logic [SZ_W-1:0] lo_eff, up_eff;
  logic [CNT_W-1:0] held_total, next_total;

  logic      accept;
  logic      full;
  logic      to_lower;
  logic      balanced;
  sample_t   smp;
  sample_t   lo_head, lo_head_d;
  sample_t   up_head, up_head_d;
  sample_t   moved;
  chain_op_t lo_op, up_op;

  logic      out_valid_q, out_valid_d;
  median_t   median_q, median_d;
  logic [COUNT_W-1:0] count_q;
  logic      dropped_q;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign smp        = sample_t'(sample_i);

  assign lo_eff     = restart_i ? '0 : lo_size_q;
  assign up_eff     = restart_i ? '0 : up_size_q;
  assign held_total = CNT_W'(lo_size_q) + CNT_W'(up_size_q);
  assign full       = !restart_i && (held_total >= CNT_W'(CAPACITY));
  assign balanced   = (lo_eff == up_eff);
  assign to_lower   = (lo_eff == '0) || (smp <= lo_head);

  // Head of the upper half that falls to the lower half after an upper insert.
  assign moved = ((up_eff == '0) || (smp < up_head)) ? smp : up_head;

  always_comb begin
    lo_op.ins = accept && !full && (to_lower || balanced);
    lo_op.pop = to_lower && !balanced;
    lo_op.val = to_lower ? smp : moved;
    up_op.ins = accept && !full && (!to_lower || !balanced);
    up_op.pop = !to_lower && balanced;
    up_op.val = to_lower ? lo_head : smp;
  end

  always_comb begin
    lo_size_d = lo_size_q;
    up_size_d = up_size_q;
    if (accept && !full) begin
      lo_size_d = lo_eff + SZ_W'(balanced);
      up_size_d = up_eff + SZ_W'(!balanced);
    end
  end

  rm_chain #(
    .DEPTH (LCAP),
    .SZ_W  (SZ_W),
    .DESC  (1'b1)
  ) u_lower (
    .clk_i    (clk_i),
    .size_i   (lo_eff),
    .op_i     (lo_op),
    .head_o   (lo_head),
    .head_d_o (lo_head_d)
  );

  rm_chain #(
    .DEPTH (UCAP),
    .SZ_W  (SZ_W),
    .DESC  (1'b0)
  ) u_upper (
    .clk_i    (clk_i),
    .size_i   (up_eff),
    .op_i     (up_op),
    .head_o   (up_head),
    .head_d_o (up_head_d)
  );

  // The lower half holds the extra sample when the count is odd.
  always_comb begin
    if (lo_size_d != up_size_d) begin
      median_d = {lo_head_d, 1'b0};
    end else begin
      median_d = MEDIAN_W'(lo_head_d) + MEDIAN_W'(up_head_d);
    end
  end

  assign next_total  = CNT_W'(lo_size_d) + CNT_W'(up_size_d);
  assign out_valid_d = accept || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_size_q   <= '0;
      up_size_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      lo_size_q   <= lo_size_d;
      up_size_q   <= up_size_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      median_q  <= median_d;
      count_q   <= COUNT_W'(next_total);
      dropped_q <= full;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign median_twice_o = median_q;
  assign sample_count_o = count_q;
  assign dropped_o      = dropped_q;

endmodule

FILE: tb/tb_running_median.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_running_median: self-checking testbench for the running median block
// Drives samples with random bursts and gaps, stalls the output at random and
// twice for a long stretch, and checks every result against a sorted-list
// model of the held samples kept in a small scoreboard.
// ----------------------------------------------------------------------------
module tb_running_median;
  import rm_pkg::*;

  localparam int          CAPACITY    = 64;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int          RANDOM_ITEMS = 1700;
  localparam int          MAX_REPORTS = 10;

  typedef struct {
    median_t              median_twice;
    logic [COUNT_W-1:0]   sample_count;
    logic                 dropped;
  } median_result_t;

  // Keeps the held samples in ascending order and the results still owed.
  class median_scoreboard;
    sample_t        held[$];
    median_result_t owed[$];
    int             capacity;
    int             errors;

    function new(int cap);
      capacity = cap;
      errors   = 0;
    endfunction

    function void note_sample(sample_t s, logic restart);
      median_result_t r;
      int             pos;
      int             n;
      int             twice;
      if (restart) held.delete();
      r.dropped = (held.size() >= capacity);
      if (!r.dropped) begin
        // Equal samples go after the ones already held.
        pos = held.size();
        while (pos > 0 && held[pos-1] > s) pos--;
        held.insert(pos, s);
      end
      n = held.size();
      if (n == 0) twice = 0;
      else if (n % 2 == 1) twice = 2 * int'(held[(n-1)/2]);
      else twice = int'(held[n/2-1]) + int'(held[n/2]);
      r.median_twice = median_t'(twice);
      r.sample_count = COUNT_W'(n);
      owed.push_back(r);
    endfunction

    function void check_result(median_t med, logic [COUNT_W-1:0] cnt, logic drp);
      median_result_t r;
      if (owed.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected result: median_twice=%0d count=%0d dropped=%0b",
                   med, cnt, drp);
        return;
      end
      r = owed.pop_front();
      if (med !== r.median_twice || cnt !== r.sample_count || drp !== r.dropped) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("mismatch: expected median_twice=%0d count=%0d dropped=%0b, got %0d %0d %0b",
                   r.median_twice, r.sample_count, r.dropped, med, cnt, drp);
      end
    endfunction

    function int pending();
      return owed.size();
    endfunction
  endclass

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  logic [SAMPLE_W-1:0] sample_i    = '0;
  logic                restart_i   = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [MEDIAN_W-1:0] median_twice_o;
  logic [COUNT_W-1:0]  sample_count_o;
  logic                dropped_o;

  median_scoreboard    sb;
  bit                  long_hold_req = 1'b0;
  int                  burst_left    = 0;
  int unsigned         cycle_cnt     = 0;

  always #4 clk_i = ~clk_i;

  running_median #(.CAPACITY(CAPACITY)) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .sample_i       (sample_i),
    .restart_i      (restart_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .median_twice_o (median_twice_o),
    .sample_count_o (sample_count_o),
    .dropped_o      (dropped_o)
  );

  // Both channels are observed in one place so that an input transaction is
  // always noted before any result of the same edge is checked.
  always @(posedge clk_i) begin
    if (rst_ni && sb != null) begin
      if (in_valid_i && !in_stall_o) sb.note_sample(sample_t'(sample_i), restart_i);
      if (out_valid_o && !out_stall_i)
        sb.check_result(median_t'(median_twice_o), sample_count_o, dropped_o);
    end
  end

  task automatic push_sample(input sample_t s, input logic restart);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    sample_i   <= s;
    restart_i  <= restart;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Sender works in bursts; a gap of idle cycles may precede each burst.
  task automatic send_item(input sample_t s, input logic restart);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(3) != 0) begin
        gap = $urandom_range(1, 6);
        repeat (gap) begin
          @(negedge clk_i);
          in_valid_i <= 1'b0;
          sample_i   <= sample_t'($urandom);
          restart_i  <= 1'($urandom);
        end
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    push_sample(s, restart);
  endtask

  function automatic sample_t pick_sample();
    int sel;
    int v;
    sel = $urandom_range(9);
    if (sel < 6) return sample_t'($urandom);
    if (sel < 9) begin
      // A narrow range makes equal samples common.
      v = int'($urandom_range(8)) - 4;
      return sample_t'(v);
    end
    return $urandom_range(1) ? sample_t'(16'h7FFF) : sample_t'(16'h8000);
  endfunction

  // Receiver stall pattern, with a long hold-off whenever one is requested.
  initial begin
    int mode;
    int len;
    @(posedge rst_ni);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        repeat (300) begin
          @(negedge clk_i);
          out_stall_i <= 1'b1;
        end
      end
      mode = $urandom_range(2);
      len  = $urandom_range(1, 50);
      repeat (len) begin
        @(negedge clk_i);
        case (mode)
          0: begin
            out_stall_i <= 1'b0;
          end
          1: begin
            out_stall_i <= ($urandom_range(3) == 0);
          end
          default: begin
            out_stall_i <= ($urandom_range(1) == 0);
          end
        endcase
      end
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("tb_running_median: errors");
    $finish;
  end

  initial begin
    sample_t dir_samples[$];
    logic    dir_restart[$];
    int      sent;
    int      seg_len;
    int      sel;
    int      drain;

    sb = new(CAPACITY);

    // Extremes, restarts, even and odd counts, and runs of equal samples.
    dir_samples = '{16'sh0000, 16'sh7FFF, -16'sh8000, 16'sh7FFF, 16'sh7FFF,
                    -16'sh8000, -16'sh8000, 16'sh7FFF, -16'sh0001, 16'sh5555,
                    -16'sh5556, 16'sh0001, 16'sh0001, 16'sh0001, -16'sh0001,
                    16'sh0001, 16'sh0000, -16'sh8000, 16'sh7FFF, 16'sh0002};
    dir_restart = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0,
                    1'b1, 1'b0, 1'b0, 1'b1, 1'b0,
                    1'b0, 1'b1, 1'b0, 1'b0, 1'b0,
                    1'b0, 1'b1, 1'b0, 1'b0, 1'b0};

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_samples[i]) send_item(dir_samples[i], dir_restart[i]);

    // The first segment always overruns the store so that drops occur early.
    long_hold_req = 1'b1;
    sent = 0;
    seg_len = CAPACITY + 8;
    while (sent < RANDOM_ITEMS) begin
      for (int k = 0; k < seg_len; k++) begin
        // Mostly well-formed segments that start with a restart; a few
        // segments keep the old store and a few items restart at random.
        if (k == 0) send_item(pick_sample(), $urandom_range(9) != 0);
        else send_item(pick_sample(), $urandom_range(49) == 0);
        sent++;
      end
      if (sent > RANDOM_ITEMS / 2 && sent <= RANDOM_ITEMS / 2 + 100) long_hold_req = 1'b1;
      sel = $urandom_range(9);
      if (sel < 4) seg_len = $urandom_range(1, 12);
      else if (sel < 7) seg_len = $urandom_range(13, 50);
      else seg_len = $urandom_range(CAPACITY - 4, CAPACITY + 36);
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    drain = 0;
    while (drain < 20) begin
      @(posedge clk_i);
      drain++;
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_running_median: clean");
    end else begin
      $display("tb_running_median: errors");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/rm_pkg.sv
rtl/core/rm_cell.sv
rtl/core/rm_chain.sv
rtl/core/running_median.sv
tb/tb_running_median.sv
